### hw/rtl/tsmt_pkg.sv
// Package with the types, constants and helper functions of the timestamp-keyed minimum table.
package tsmt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CAP_W       = 5;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_RESET   = 16;
    localparam int YEAR_W      = 14;
    localparam int YEAR_FACTOR = 25;
    localparam int RECIP_MUL   = 5243;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = YEAR_W + $clog2(RECIP_MUL + 1);
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int MAX_HOUR    = 23;
    localparam int MAX_MINUTE  = 59;

    typedef enum logic [2:0] {
        REQ_INSERT       = 3'd0,
        REQ_COUNT        = 3'd1,
        REQ_QUERY_MIN    = 3'd2,
        REQ_REMOVE_MIN   = 3'd3,
        REQ_REMOVE_OWNER = 3'd4,
        REQ_CLEAR        = 3'd5
    } tsmt_req_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_BAD_DATE  = 3'd2,
        STAT_BAD_TIME  = 3'd3,
        STAT_EMPTY     = 3'd4
    } tsmt_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DATE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_RESP
    } tsmt_state_t;

    // The fields below the owner form the chronological key, most significant first.
    typedef struct packed {
        logic [15:0]       owner;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
    } tsmt_entry_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        tsmt_entry_t       data;
    } tsmt_wr_t;

    typedef struct packed {
        logic busy;
        logic ok;
    } tsmt_date_stat_t;

    typedef struct packed {
        tsmt_status_t      status;
        logic [4:0]        match_count;
        logic [4:0]        total_count;
        tsmt_entry_t       earliest;
    } tsmt_rsp_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### hw/rtl/tsmt_ifs.sv
// Request and response channel interfaces of the timestamp-keyed minimum table.
interface tsmt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] owner_id;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [13:0] year_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;

    modport source (
        output valid, req_type, owner_id, day_in, month_in, year_in, hour_in, minute_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, owner_id, day_in, month_in, year_in, hour_in, minute_in,
        output ready
    );
endinterface

interface tsmt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  match_count;
    logic [4:0]  total_count;
    logic [15:0] earliest_owner;
    logic [4:0]  earliest_day;
    logic [3:0]  earliest_month;
    logic [13:0] earliest_year;
    logic [4:0]  earliest_hour;
    logic [5:0]  earliest_minute;

    modport source (
        output valid, status, match_count, total_count, earliest_owner, earliest_day,
               earliest_month, earliest_year, earliest_hour, earliest_minute,
        input  ready
    );
    modport sink (
        input  valid, status, match_count, total_count, earliest_owner, earliest_day,
               earliest_month, earliest_year, earliest_hour, earliest_minute,
        output ready
    );
endinterface

### hw/rtl/tsmt_date_check.sv
// Calendar date checker with a leap-year test built on a reciprocal division of the year by 25.
module tsmt_date_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [4:0]                    day,
    input  logic [3:0]                    month,
    input  logic [tsmt_pkg::YEAR_W-1:0]   year,
    output tsmt_pkg::tsmt_date_stat_t     stat
);

    logic [tsmt_pkg::YEAR_W-1:0]   year_reg;
    logic [4:0]                    day_reg;
    logic [3:0]                    month_reg;
    logic [tsmt_pkg::QUOT_W-1:0]   quot_reg;
    logic                          busy_reg;
    logic [tsmt_pkg::PROD_W-1:0]   prod;
    logic [tsmt_pkg::YEAR_W-1:0]   year_back;
    logic                          div4;
    logic                          div16;
    logic                          div25;
    logic                          leap;
    logic [4:0]                    len;

    // The scaled reciprocal gives the exact quotient by 25 over the whole year range.
    always_comb
    begin
        prod = tsmt_pkg::PROD_W'(year_reg) * tsmt_pkg::PROD_W'(tsmt_pkg::RECIP_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            year_reg  <= year;
            day_reg   <= day;
            month_reg <= month;
        end
        if (busy_reg)
        begin
            quot_reg <= prod[tsmt_pkg::PROD_W-1:tsmt_pkg::RECIP_SHIFT];
        end
    end

    // A year is a multiple of 100 when it is a multiple of 4 and of 25, and a multiple of 400
    // when it is a multiple of 16 and of 25.
    always_comb
    begin
        year_back = tsmt_pkg::YEAR_W'(quot_reg) * tsmt_pkg::YEAR_W'(tsmt_pkg::YEAR_FACTOR);
        div25     = (year_back == year_reg);
        div4      = (year_reg[1:0] == 2'b00);
        div16     = (year_reg[3:0] == 4'b0000);
        leap      = div4 && (!div25 || div16);
        len       = tsmt_pkg::month_len(month_reg, leap);
        stat.busy = busy_reg;
        stat.ok   = (year_reg != '0) && (day_reg != 5'd0) && (day_reg <= len);
    end

endmodule

### hw/rtl/tsmt_store.sv
// Entry memory of the table with one write port and one registered read port.
module tsmt_store (
    input  logic                           clk,
    input  tsmt_pkg::tsmt_wr_t             wr,
    input  logic [tsmt_pkg::IDX_W-1:0]     rd_addr,
    output tsmt_pkg::tsmt_entry_t          rd_data
);

    tsmt_pkg::tsmt_entry_t mem [tsmt_pkg::TABLE_DEPTH];
    tsmt_pkg::tsmt_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/timestamp_keyed_min_table.sv
// Top level of the timestamp-keyed minimum table: request sequencer, slot scan unit and result register.
// One request is taken at a time; ready is high only while the sequencer is idle, and a finished
// result waits in the output register while the next request is taken. Every request is taken in
// the idle state and passes the decode and response states. Insert and count-on-date also pass
// the date check, whose leap-year test divides the year by 25 with a reciprocal multiplication.
// Count with a valid date, query earliest, remove earliest and remove owner scan the held entries
// through the single memory read port, one slot per cycle, and remove earliest then moves the
// last entry into the slot of the earliest through a read state and a write state. Clear, unknown
// requests and query or remove earliest on an empty table go from decode straight to the response
// state. The result is registered in the output register, and a stalled response holds the
// sequencer in the response state until the output register is free.
module timestamp_keyed_min_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tsmt_pkg::CAP_W-1:0]  cfg_wdata,
    tsmt_req_if.sink                    req,
    tsmt_rsp_if.source                  rsp
);

    tsmt_pkg::tsmt_state_t           state_reg, state_next;
    tsmt_pkg::tsmt_req_t             op_reg, op_next;
    tsmt_pkg::tsmt_entry_t           cur_reg, cur_next;
    tsmt_pkg::tsmt_entry_t           best_reg, best_next;
    logic [tsmt_pkg::IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [tsmt_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [tsmt_pkg::CNT_W-1:0]      issue_reg, issue_next;
    logic [tsmt_pkg::CNT_W-1:0]      wptr_reg, wptr_next;
    logic [tsmt_pkg::CNT_W-1:0]      match_reg, match_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic [tsmt_pkg::IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    tsmt_pkg::tsmt_status_t          status_reg, status_next;
    logic [tsmt_pkg::CAP_W-1:0]      cap_reg;
    logic                            out_valid_reg, out_valid_next;
    tsmt_pkg::tsmt_rsp_t             out_reg, out_next;

    tsmt_pkg::tsmt_wr_t              wr;
    logic [tsmt_pkg::IDX_W-1:0]      rd_addr;
    tsmt_pkg::tsmt_entry_t           rd_data;
    tsmt_pkg::tsmt_date_stat_t       date_stat;
    logic                            date_start;
    logic [tsmt_pkg::CMP_W-1:0]      limit;
    logic                            full;
    logic                            time_ok;
    logic                            issuing;
    logic                            earlier;
    logic                            same_date;
    logic                            show_min;

    tsmt_date_check u_date_check (
        .clk   (clk),
        .rst_n (rst_n),
        .start (date_start),
        .day   (req.day_in),
        .month (req.month_in),
        .year  (req.year_in),
        .stat  (date_stat)
    );

    tsmt_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (tsmt_pkg::CMP_W'(cap_reg) > tsmt_pkg::CMP_W'(tsmt_pkg::TABLE_DEPTH))
        begin
            limit = tsmt_pkg::CMP_W'(tsmt_pkg::TABLE_DEPTH);
        end
        else
        begin
            limit = tsmt_pkg::CMP_W'(cap_reg);
        end
        full      = (tsmt_pkg::CMP_W'(count_reg) >= limit);
        time_ok   = (cur_reg.hour <= 5'(tsmt_pkg::MAX_HOUR)) &&
                    (cur_reg.minute <= 6'(tsmt_pkg::MAX_MINUTE));
        issuing   = (issue_reg < count_reg);
        earlier   = ({rd_data.year, rd_data.month, rd_data.day, rd_data.hour, rd_data.minute} <
                     {best_reg.year, best_reg.month, best_reg.day, best_reg.hour,
                      best_reg.minute});
        same_date = ({rd_data.year, rd_data.month, rd_data.day} ==
                     {cur_reg.year, cur_reg.month, cur_reg.day});
        show_min  = ((op_reg == tsmt_pkg::REQ_QUERY_MIN) ||
                     (op_reg == tsmt_pkg::REQ_REMOVE_MIN)) &&
                    (status_reg == tsmt_pkg::STAT_OK);
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        wptr_next      = wptr_reg;
        match_next     = match_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        rd_vld_next    = 1'b0;
        rd_idx_next    = issue_reg[tsmt_pkg::IDX_W-1:0];
        rd_addr        = issue_reg[tsmt_pkg::IDX_W-1:0];
        date_start     = 1'b0;
        wr             = '0;
        req.ready      = (state_reg == tsmt_pkg::ST_IDLE);

        case (state_reg)
            tsmt_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = tsmt_pkg::tsmt_req_t'(req.req_type);
                    cur_next.owner  = req.owner_id;
                    cur_next.year   = req.year_in;
                    cur_next.month  = req.month_in;
                    cur_next.day    = req.day_in;
                    cur_next.hour   = req.hour_in;
                    cur_next.minute = req.minute_in;
                    date_start      = 1'b1;
                    state_next      = tsmt_pkg::ST_DECODE;
                end
            end

            tsmt_pkg::ST_DECODE:
            begin
                match_next  = '0;
                issue_next  = '0;
                wptr_next   = '0;
                status_next = tsmt_pkg::STAT_OK;
                case (op_reg)
                    tsmt_pkg::REQ_INSERT, tsmt_pkg::REQ_COUNT:
                    begin
                        state_next = tsmt_pkg::ST_DATE;
                    end
                    tsmt_pkg::REQ_QUERY_MIN, tsmt_pkg::REQ_REMOVE_MIN:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = tsmt_pkg::STAT_EMPTY;
                            state_next  = tsmt_pkg::ST_RESP;
                        end
                        else
                        begin
                            state_next = tsmt_pkg::ST_SCAN;
                        end
                    end
                    tsmt_pkg::REQ_REMOVE_OWNER:
                    begin
                        state_next = tsmt_pkg::ST_SCAN;
                    end
                    tsmt_pkg::REQ_CLEAR:
                    begin
                        count_next = '0;
                        state_next = tsmt_pkg::ST_RESP;
                    end
                    default:
                    begin
                        state_next = tsmt_pkg::ST_RESP;
                    end
                endcase
            end

            tsmt_pkg::ST_DATE:
            begin
                if (!date_stat.busy)
                begin
                    state_next = tsmt_pkg::ST_RESP;
                    if (op_reg == tsmt_pkg::REQ_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = tsmt_pkg::STAT_FULL;
                        end
                        else if (!date_stat.ok)
                        begin
                            status_next = tsmt_pkg::STAT_BAD_DATE;
                        end
                        else if (!time_ok)
                        begin
                            status_next = tsmt_pkg::STAT_BAD_TIME;
                        end
                        else
                        begin
                            wr.en      = 1'b1;
                            wr.addr    = count_reg[tsmt_pkg::IDX_W-1:0];
                            wr.data    = cur_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (!date_stat.ok)
                    begin
                        status_next = tsmt_pkg::STAT_BAD_DATE;
                    end
                    else
                    begin
                        state_next = tsmt_pkg::ST_SCAN;
                    end
                end
            end

            tsmt_pkg::ST_SCAN:
            begin
                if (issuing)
                begin
                    issue_next  = issue_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    case (op_reg)
                        tsmt_pkg::REQ_COUNT:
                        begin
                            if (same_date)
                            begin
                                match_next = match_reg + 1'b1;
                            end
                        end
                        tsmt_pkg::REQ_QUERY_MIN, tsmt_pkg::REQ_REMOVE_MIN:
                        begin
                            if ((rd_idx_reg == '0) || earlier)
                            begin
                                best_next     = rd_data;
                                best_idx_next = rd_idx_reg;
                            end
                        end
                        tsmt_pkg::REQ_REMOVE_OWNER:
                        begin
                            if (rd_data.owner != cur_reg.owner)
                            begin
                                wr.en     = 1'b1;
                                wr.addr   = wptr_reg[tsmt_pkg::IDX_W-1:0];
                                wr.data   = rd_data;
                                wptr_next = wptr_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (!issuing && !rd_vld_reg)
                begin
                    if (op_reg == tsmt_pkg::REQ_REMOVE_MIN)
                    begin
                        state_next = tsmt_pkg::ST_MOVE_RD;
                    end
                    else
                    begin
                        if (op_reg == tsmt_pkg::REQ_REMOVE_OWNER)
                        begin
                            count_next = wptr_reg;
                        end
                        state_next = tsmt_pkg::ST_RESP;
                    end
                end
            end

            tsmt_pkg::ST_MOVE_RD:
            begin
                rd_addr    = tsmt_pkg::IDX_W'(count_reg - 1'b1);
                state_next = tsmt_pkg::ST_MOVE_WR;
            end

            tsmt_pkg::ST_MOVE_WR:
            begin
                wr.en      = 1'b1;
                wr.addr    = best_idx_reg;
                wr.data    = rd_data;
                count_next = count_reg - 1'b1;
                state_next = tsmt_pkg::ST_RESP;
            end

            tsmt_pkg::ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = status_reg;
                    out_next.match_count = 5'(match_reg);
                    out_next.total_count = 5'(count_reg);
                    out_next.earliest    = show_min ? best_reg : '0;
                    state_next           = tsmt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tsmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsmt_pkg::ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= tsmt_pkg::CAP_W'(tsmt_pkg::CAP_RESET);
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_vld_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        issue_reg    <= issue_next;
        wptr_reg     <= wptr_next;
        match_reg    <= match_next;
        status_reg   <= status_next;
        rd_idx_reg   <= rd_idx_next;
        out_reg      <= out_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.match_count     = out_reg.match_count;
    assign rsp.total_count     = out_reg.total_count;
    assign rsp.earliest_owner  = out_reg.earliest.owner;
    assign rsp.earliest_day    = out_reg.earliest.day;
    assign rsp.earliest_month  = out_reg.earliest.month;
    assign rsp.earliest_year   = out_reg.earliest.year;
    assign rsp.earliest_hour   = out_reg.earliest.hour;
    assign rsp.earliest_minute = out_reg.earliest.minute;

`ifndef SYNTHESIS
    // The table never holds more entries than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tsmt_pkg::CNT_W'(tsmt_pkg::TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // A new result is only ever presented from the response state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == tsmt_pkg::ST_RESP))
        else $error("result presented outside the response state");

    // The memory is never written while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsmt_pkg::ST_IDLE) |-> !wr.en)
        else $error("memory written while idle");

    // A scan read never targets a slot at or beyond the entry count.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_next |-> (issue_reg < count_reg))
        else $error("scan read beyond the held entries");
`endif

endmodule

### tb/sv/timestamp_keyed_min_table_checker.sv
// Checker that predicts every response of the timestamp-keyed minimum table and compares it.
`timescale 1ns / 1ps

module timestamp_keyed_min_table_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [tsmt_pkg::CAP_W-1:0] cfg_wdata,
    tsmt_req_if                        req,
    tsmt_rsp_if                        rsp,
    output int                         mismatches,
    output int                         awaiting
);
    import tsmt_pkg::*;

    tsmt_entry_t      slots [TABLE_DEPTH];
    int               held;
    logic [CAP_W-1:0] cap_limit;
    tsmt_rsp_t        predicted_rsps [$];
    tsmt_rsp_t        want;
    tsmt_entry_t      seen;
    int               errors;

    function automatic bit leap_year(input logic [13:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic bit date_valid(input logic [4:0] d, input logic [3:0] m,
                                      input logic [13:0] y);
        logic [4:0] last;
        case (m)
            4'd2:                    last = leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: last = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:      last = 5'd31;
            default:                 last = 5'd0;
        endcase
        return (y != 0) && (d != 0) && (d <= last);
    endfunction

    function automatic logic [33:0] chrono_key(input tsmt_entry_t e);
        return {e.year, e.month, e.day, e.hour, e.minute};
    endfunction

    function automatic int earliest_slot();
        int best;
        best = 0;
        for (int i = 1; i < held; i++)
        begin
            if (chrono_key(slots[i]) < chrono_key(slots[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic tsmt_rsp_t serve_request(input logic [2:0] kind, input tsmt_entry_t e);
        tsmt_rsp_t r;
        int        lim;
        int        w;
        int        pick;
        r = '0;
        r.status = STAT_OK;
        lim = (cap_limit < TABLE_DEPTH) ? int'(cap_limit) : TABLE_DEPTH;
        case (kind)
            REQ_INSERT:
            begin
                if (held >= lim)
                    r.status = STAT_FULL;
                else if (!date_valid(e.day, e.month, e.year))
                    r.status = STAT_BAD_DATE;
                else if (e.hour > MAX_HOUR || e.minute > MAX_MINUTE)
                    r.status = STAT_BAD_TIME;
                else
                begin
                    slots[held] = e;
                    held++;
                end
            end
            REQ_COUNT:
            begin
                if (!date_valid(e.day, e.month, e.year))
                    r.status = STAT_BAD_DATE;
                else
                begin
                    for (int i = 0; i < held; i++)
                    begin
                        if (slots[i].day == e.day && slots[i].month == e.month &&
                            slots[i].year == e.year)
                            r.match_count++;
                    end
                end
            end
            REQ_QUERY_MIN:
            begin
                if (held == 0)
                    r.status = STAT_EMPTY;
                else
                    r.earliest = slots[earliest_slot()];
            end
            REQ_REMOVE_MIN:
            begin
                if (held == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    pick = earliest_slot();
                    r.earliest = slots[pick];
                    slots[pick] = slots[held - 1];
                    held--;
                end
            end
            REQ_REMOVE_OWNER:
            begin
                w = 0;
                for (int i = 0; i < held; i++)
                begin
                    if (slots[i].owner != e.owner)
                    begin
                        slots[w] = slots[i];
                        w++;
                    end
                end
                held = w;
            end
            REQ_CLEAR:
                held = 0;
            default:
                ;
        endcase
        r.total_count = 5'(held);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            cap_limit = CAP_W'(CAP_RESET);
            predicted_rsps.delete();
            errors = 0;
            mismatches <= 0;
            awaiting <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_rsps.size() == 0)
                begin
                    $error("response transfer with no request waiting for it");
                    errors++;
                end
                else
                begin
                    want = predicted_rsps.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("match_count", want.match_count, rsp.match_count);
                    check_field("total_count", want.total_count, rsp.total_count);
                    check_field("earliest_owner", want.earliest.owner, rsp.earliest_owner);
                    check_field("earliest_day", want.earliest.day, rsp.earliest_day);
                    check_field("earliest_month", want.earliest.month, rsp.earliest_month);
                    check_field("earliest_year", want.earliest.year, rsp.earliest_year);
                    check_field("earliest_hour", want.earliest.hour, rsp.earliest_hour);
                    check_field("earliest_minute", want.earliest.minute, rsp.earliest_minute);
                end
            end
            if (req.valid && req.ready)
            begin
                seen.owner  = req.owner_id;
                seen.day    = req.day_in;
                seen.month  = req.month_in;
                seen.year   = req.year_in;
                seen.hour   = req.hour_in;
                seen.minute = req.minute_in;
                predicted_rsps.push_back(serve_request(req.req_type, seen));
            end
            if (cfg_we)
                cap_limit = cfg_wdata;
            mismatches <= errors;
            awaiting <= predicted_rsps.size();
        end
    end

endmodule

### tb/sv/timestamp_keyed_min_table_test.sv
// Top of the timestamp-keyed minimum table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module timestamp_keyed_min_table_test;
    import tsmt_pkg::*;

    localparam logic [2:0] REQ_SPARE_LO    = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI    = 3'd7;
    localparam int         ITEMS_PER_PHASE = 200;
    localparam int         HOLD_AT         = 120;
    localparam int         LONG_HOLD       = 200;

    typedef struct packed {
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
    } cal_date_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    int               mismatches;
    int               awaiting;
    int               sent = 0;
    int               received = 0;
    int               cap_settings = 0;
    cal_date_t        date_pool [6];
    logic [CAP_W-1:0] cap_plan [8];

    tsmt_req_if req_ch ();
    tsmt_rsp_if rsp_ch ();

    timestamp_keyed_min_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    timestamp_keyed_min_table_checker table_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_req(input logic [2:0] kind, input logic [15:0] owner,
                            input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
                            input logic [4:0] h, input logic [5:0] mi);
        int gap;
        gap = (sent >= 900 && sent < 1100) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.owner_id  <= owner;
        req_ch.day_in    <= d;
        req_ch.month_in  <= m;
        req_ch.year_in   <= y;
        req_ch.hour_in   <= h;
        req_ch.minute_in <= mi;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        sent++;
    endtask

    task automatic send_random();
        int          pick;
        int          slot;
        logic [2:0]  kind;
        logic [15:0] owner;
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
        logic [4:0]  h;
        logic [5:0]  mi;
        pick  = $urandom_range(0, 99);
        slot  = $urandom_range(0, 5);
        owner = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        if ($urandom_range(0, 2) != 0)
        begin
            d = date_pool[slot].d;
            m = date_pool[slot].m;
            y = date_pool[slot].y;
        end
        else
        begin
            d = 5'($urandom_range(1, 28));
            m = 4'($urandom_range(1, 12));
            y = 14'($urandom_range(1, 16383));
        end
        h  = $urandom_range(0, 1) ? 5'($urandom_range(0, 23)) : 5'd9;
        mi = $urandom_range(0, 1) ? 6'($urandom_range(0, 59)) : 6'(15 * $urandom_range(0, 3));
        if (pick < 40)
        begin
            kind = REQ_INSERT;
            if (pick >= 34)
            begin
                d  = 5'($urandom);
                m  = 4'($urandom);
                h  = 5'($urandom);
                mi = 6'($urandom);
            end
        end
        else if (pick < 52)
        begin
            kind = REQ_COUNT;
            if (pick >= 49)
            begin
                d = 5'($urandom);
                m = 4'($urandom);
                y = 14'($urandom);
            end
        end
        else if (pick < 62)
            kind = REQ_QUERY_MIN;
        else if (pick < 74)
            kind = REQ_REMOVE_MIN;
        else if (pick < 82)
            kind = REQ_REMOVE_OWNER;
        else if (pick < 85)
            kind = REQ_CLEAR;
        else if (pick < 88)
            kind = pick[0] ? REQ_SPARE_HI : REQ_SPARE_LO;
        else
        begin
            kind  = 3'($urandom);
            owner = 16'($urandom);
            d     = 5'($urandom);
            m     = 4'($urandom);
            y     = 14'($urandom);
            h     = 5'($urandom);
            mi    = 6'($urandom);
        end
        send_req(kind, owner, d, m, y, h, mi);
    endtask

    task automatic drain(input int settle);
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (awaiting != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_settings++;
    endtask

    initial
    begin : response_side
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (received == HOLD_AT)
                stall = LONG_HOLD;
            else if (received >= 300 && received < 500)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
            received++;
        end
    end

    initial
    begin : stimulus
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_INSERT;
        req_ch.owner_id  <= '0;
        req_ch.day_in    <= '0;
        req_ch.month_in  <= '0;
        req_ch.year_in   <= '0;
        req_ch.hour_in   <= '0;
        req_ch.minute_in <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, date and time limits, leap years, ties and every request kind.
        send_req(REQ_QUERY_MIN, '0, '0, '0, '0, '0, '0);
        send_req(REQ_REMOVE_MIN, '0, '0, '0, '0, '0, '0);
        send_req(REQ_INSERT, 16'hffff, 5'd31, 4'd12, 14'd16383, 5'd23, 6'd59);
        send_req(REQ_INSERT, 16'd1, 5'd29, 4'd2, 14'd2000, 5'd12, 6'd30);
        send_req(REQ_INSERT, 16'd2, 5'd29, 4'd2, 14'd1900, 5'd12, 6'd30);
        send_req(REQ_INSERT, 16'd3, 5'd29, 4'd2, 14'd2024, 5'd0, 6'd0);
        send_req(REQ_INSERT, 16'd4, 5'd29, 4'd2, 14'd2023, 5'd0, 6'd0);
        send_req(REQ_INSERT, 16'd5, 5'd0, 4'd1, 14'd2000, 5'd1, 6'd1);
        send_req(REQ_INSERT, 16'd5, 5'd31, 4'd4, 14'd2000, 5'd1, 6'd1);
        send_req(REQ_INSERT, 16'd5, 5'd1, 4'd15, 14'd2000, 5'd1, 6'd1);
        send_req(REQ_INSERT, 16'd5, 5'd1, 4'd0, 14'd2000, 5'd1, 6'd1);
        send_req(REQ_INSERT, 16'd5, 5'd1, 4'd1, 14'd0, 5'd1, 6'd1);
        send_req(REQ_INSERT, 16'd6, 5'd1, 4'd1, 14'd2000, 5'd24, 6'd0);
        send_req(REQ_INSERT, 16'd6, 5'd1, 4'd1, 14'd2000, 5'd0, 6'd60);
        send_req(REQ_INSERT, 16'd6, 5'd31, 4'd1, 14'd2000, 5'd31, 6'd63);
        send_req(REQ_INSERT, 16'd7, 5'd0, 4'd0, 14'd0, 5'd31, 6'd63);
        send_req(REQ_INSERT, 16'd0, 5'd1, 4'd1, 14'd1, 5'd0, 6'd0);
        send_req(REQ_INSERT, 16'd8, 5'd1, 4'd1, 14'd1, 5'd0, 6'd0);
        send_req(REQ_COUNT, '0, 5'd1, 4'd1, 14'd1, '0, '0);
        send_req(REQ_COUNT, '0, 5'd30, 4'd2, 14'd2000, '0, '0);
        send_req(REQ_QUERY_MIN, '0, '0, '0, '0, '0, '0);
        send_req(REQ_REMOVE_MIN, '0, '0, '0, '0, '0, '0);
        send_req(REQ_REMOVE_OWNER, 16'h1234, '0, '0, '0, '0, '0);
        send_req(REQ_REMOVE_OWNER, 16'd8, '0, '0, '0, '0, '0);
        send_req(REQ_SPARE_LO, 16'd1, 5'd1, 4'd1, 14'd1, '0, '0);
        send_req(REQ_SPARE_HI, 16'd1, 5'd1, 4'd1, 14'd1, '0, '0);
        send_req(REQ_CLEAR, '0, '0, '0, '0, '0, '0);

        cap_plan = '{5'd31, 5'd2, 5'd0, 5'd16, 5'd1, 5'd8, 5'd17, 5'($urandom)};
        foreach (cap_plan[p])
        begin
            drain(20);
            set_capacity(cap_plan[p]);
            for (int i = 0; i < 6; i++)
            begin
                date_pool[i].d = 5'($urandom_range(1, 31));
                date_pool[i].m = 4'($urandom_range(1, 12));
                date_pool[i].y = 14'($urandom_range(1, 16383));
            end
            date_pool[0] = '{5'd29, 4'd2, 14'(4 * $urandom_range(1, 4095))};
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random();
            // Leave the table full so that the next, lower capacity starts below the count.
            if (cap_plan[p] == 5'd31)
            begin
                for (int n = 0; n < 18; n++)
                    send_req(REQ_INSERT, 16'($urandom), 5'($urandom_range(1, 28)),
                             4'($urandom_range(1, 12)), 14'($urandom_range(1, 16383)),
                             5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
            end
        end

        drain(40);
        $display("Covered %0d requests and %0d responses over %0d capacity settings.",
                 sent, received, cap_settings + 1);
        $display("The response side held off once for %0d cycles to stall the request side.",
                 LONG_HOLD);
        if (mismatches == 0 && awaiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tsmt_pkg.sv
hw/rtl/tsmt_ifs.sv
hw/rtl/tsmt_date_check.sv
hw/rtl/tsmt_store.sv
hw/rtl/timestamp_keyed_min_table.sv
tb/sv/timestamp_keyed_min_table_checker.sv
tb/sv/timestamp_keyed_min_table_test.sv
